### hw/rtl/palt_pkg.sv
package palt_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] OP_OBSERVE = 2'd0;
  localparam logic [1:0] OP_READ    = 2'd1;
  localparam logic [1:0] OP_CLEAR   = 2'd2;

  localparam logic [2:0] ST_UPDATED  = 3'd0;
  localparam logic [2:0] ST_INSERTED = 3'd1;
  localparam logic [2:0] ST_DROPPED  = 3'd2;
  localparam logic [2:0] ST_READ_OK  = 3'd3;
  localparam logic [2:0] ST_RANGE    = 3'd4;
  localparam logic [2:0] ST_CLEARED  = 3'd5;

  typedef struct packed {
    logic [1:0]        operation;
    logic [47:0]       peer_address;
    logic signed [7:0] signal_strength;
    logic [31:0]       time_ms;
    logic [IDX_W-1:0]  read_index;
  } item_t;

endpackage

### hw/rtl/palt_front.sv
module palt_front
  import palt_pkg::*;
(
  input  logic              start,
  input  logic              q_full,
  input  logic [1:0]        operation,
  input  logic [47:0]       peer_address,
  input  logic signed [7:0] signal_strength,
  input  logic [31:0]       time_ms,
  input  logic [IDX_W-1:0]  read_index,
  output logic              busy,
  output logic              push,
  output item_t             item
);

  logic known_op;

  always_comb begin
    case (operation)
      OP_OBSERVE: known_op = 1'b1;
      OP_READ:    known_op = 1'b1;
      OP_CLEAR:   known_op = 1'b1;
      default:    known_op = 1'b0;
    endcase
  end

  assign busy = q_full;
  // unknown codes are taken and dropped here
  assign push = start && !q_full && known_op;

  always_comb begin
    item.operation       = operation;
    item.peer_address    = peer_address;
    item.signal_strength = signal_strength;
    item.time_ms         = time_ms;
    item.read_index      = read_index;
  end

endmodule

### hw/rtl/palt_queue.sv
module palt_queue
  import palt_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  input  logic  pop,
  output logic  full,
  output logic  not_empty,
  output item_t head
);

  item_t             slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QCNT_W-1:0] count;

  assign full      = (count == QCNT_W'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head      = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

### hw/rtl/palt_back.sv
module palt_back
  import palt_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  item_t             q_item,
  output logic              pop,
  output logic              done,
  output logic [2:0]        status,
  output logic [IDX_W-1:0]  entry_index,
  output logic [CNT_W-1:0]  entry_total,
  output logic [47:0]       entry_address,
  output logic signed [7:0] entry_strength,
  output logic [31:0]       entry_packets,
  output logic [31:0]       entry_last_seen
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SEARCH = 2'd1;
  localparam logic [1:0] S_READ   = 2'd2;

  logic [47:0]       addr_mem [TABLE_DEPTH];
  logic [7:0]        str_mem  [TABLE_DEPTH];
  logic [31:0]       pkt_mem  [TABLE_DEPTH];
  logic [31:0]       seen_mem [TABLE_DEPTH];

  logic [1:0]        state;
  logic [CNT_W-1:0]  fill;
  item_t             cur;
  logic [CNT_W-1:0]  scan;
  logic              cmp_valid;
  logic [IDX_W-1:0]  cmp_idx;
  logic [47:0]       addr_q;
  logic [7:0]        str_q;
  logic [31:0]       pkt_q;
  logic [31:0]       seen_q;

  logic [IDX_W-1:0]  rd_idx;
  logic              hit;
  logic              more;
  logic              is_full;
  logic              mem_we;
  logic              addr_we;
  logic [IDX_W-1:0]  wr_idx;
  logic [31:0]       pkt_wr;

  assign rd_idx  = (state == S_IDLE) ? q_item.read_index : scan[IDX_W-1:0];
  assign hit     = cmp_valid && (addr_q == cur.peer_address);
  assign more    = (scan < fill);
  assign is_full = (fill == CNT_W'(TABLE_DEPTH));
  assign pop     = (state == S_IDLE) && q_valid;

  always_comb begin
    mem_we  = 1'b0;
    addr_we = 1'b0;
    wr_idx  = cmp_idx;
    pkt_wr  = pkt_q + 32'd1;
    if (state == S_SEARCH) begin
      if (hit) begin
        mem_we = 1'b1;
      end else if (!more && !is_full) begin
        mem_we  = 1'b1;
        addr_we = 1'b1;
        wr_idx  = fill[IDX_W-1:0];
        pkt_wr  = 32'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      str_mem[wr_idx]  <= cur.signal_strength;
      pkt_mem[wr_idx]  <= pkt_wr;
      seen_mem[wr_idx] <= cur.time_ms;
    end
    if (addr_we) begin
      addr_mem[wr_idx] <= cur.peer_address;
    end
    addr_q <= addr_mem[rd_idx];
    str_q  <= str_mem[rd_idx];
    pkt_q  <= pkt_mem[rd_idx];
    seen_q <= seen_mem[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill      <= '0;
      cmp_valid <= 1'b0;
      done      <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            cur       <= q_item;
            scan      <= '0;
            cmp_valid <= 1'b0;
            case (q_item.operation)
              OP_OBSERVE: begin
                state <= S_SEARCH;
              end
              OP_READ: begin
                if (CNT_W'(q_item.read_index) < fill) begin
                  state <= S_READ;
                end else begin
                  done            <= 1'b1;
                  status          <= ST_RANGE;
                  entry_index     <= '0;
                  entry_total     <= fill;
                  entry_address   <= '0;
                  entry_strength  <= '0;
                  entry_packets   <= '0;
                  entry_last_seen <= '0;
                end
              end
              default: begin
                fill            <= '0;
                done            <= 1'b1;
                status          <= ST_CLEARED;
                entry_index     <= '0;
                entry_total     <= '0;
                entry_address   <= '0;
                entry_strength  <= '0;
                entry_packets   <= '0;
                entry_last_seen <= '0;
              end
            endcase
          end
        end
        S_SEARCH: begin
          if (hit) begin
            state           <= S_IDLE;
            done            <= 1'b1;
            status          <= ST_UPDATED;
            entry_index     <= cmp_idx;
            entry_total     <= fill;
            entry_address   <= addr_q;
            entry_strength  <= cur.signal_strength;
            entry_packets   <= pkt_wr;
            entry_last_seen <= cur.time_ms;
          end else if (more) begin
            cmp_valid <= 1'b1;
            cmp_idx   <= scan[IDX_W-1:0];
            scan      <= scan + 1'b1;
          end else if (is_full) begin
            state           <= S_IDLE;
            done            <= 1'b1;
            status          <= ST_DROPPED;
            entry_index     <= '0;
            entry_total     <= fill;
            entry_address   <= '0;
            entry_strength  <= '0;
            entry_packets   <= '0;
            entry_last_seen <= '0;
          end else begin
            state           <= S_IDLE;
            fill            <= fill + 1'b1;
            done            <= 1'b1;
            status          <= ST_INSERTED;
            entry_index     <= fill[IDX_W-1:0];
            entry_total     <= fill + 1'b1;
            entry_address   <= cur.peer_address;
            entry_strength  <= cur.signal_strength;
            entry_packets   <= 32'd1;
            entry_last_seen <= cur.time_ms;
          end
        end
        S_READ: begin
          state           <= S_IDLE;
          done            <= 1'b1;
          status          <= ST_READ_OK;
          entry_index     <= cur.read_index;
          entry_total     <= fill;
          entry_address   <= addr_q;
          entry_strength  <= str_q;
          entry_packets   <= pkt_q;
          entry_last_seen <= seen_q;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### hw/rtl/peer_address_learning_table.sv
// observe: linear scan from queue head to done (one entry read from the address
// memory per cycle) until a hit or the end of the filled part of the table
// read passes through S_READ; clear and out of range read finish from S_IDLE; all go through the queue
// a two-entry queue takes new transactions while the back end searches
// rst clears the fill count, queue and strobe; table memories are not cleared
// done is high for one cycle per result; the receiver cannot stall
module peer_address_learning_table
  import palt_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        operation,
  input  logic [47:0]       peer_address,
  input  logic signed [7:0] signal_strength,
  input  logic [31:0]       time_ms,
  input  logic [5:0]        read_index,
  output logic              done,
  output logic [2:0]        status,
  output logic [5:0]        entry_index,
  output logic [6:0]        entry_total,
  output logic [47:0]       entry_address,
  output logic signed [7:0] entry_strength,
  output logic [31:0]       entry_packets,
  output logic [31:0]       entry_last_seen
);

  logic  q_full;
  logic  push;
  item_t push_item;
  logic  q_valid;
  item_t q_item;
  logic  pop;

  palt_front u_front (
    .start           (start),
    .q_full          (q_full),
    .operation       (operation),
    .peer_address    (peer_address),
    .signal_strength (signal_strength),
    .time_ms         (time_ms),
    .read_index      (read_index),
    .busy            (busy),
    .push            (push),
    .item            (push_item)
  );

  palt_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_valid),
    .head      (q_item)
  );

  palt_back u_back (
    .clk             (clk),
    .rst             (rst),
    .q_valid         (q_valid),
    .q_item          (q_item),
    .pop             (pop),
    .done            (done),
    .status          (status),
    .entry_index     (entry_index),
    .entry_total     (entry_total),
    .entry_address   (entry_address),
    .entry_strength  (entry_strength),
    .entry_packets   (entry_packets),
    .entry_last_seen (entry_last_seen)
  );

endmodule
